>>> hdl/cntab_pkg.sv
// Shared types, constants and helper functions of the connection tracking table.
`default_nettype none
package cntab_pkg;

   localparam int ENTRIES = 1024;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int FILL_W  = IDX_W + 1;
   localparam int STAMP_W = 64;

   localparam logic [7:0] PROTO_UDP  = 8'h11;
   localparam logic [7:0] PROTO_ICMP = 8'h01;

   localparam logic [3:0] ST_NEW = 4'h1;
   localparam logic [3:0] ST_RPL = 4'h2;
   localparam logic [3:0] ST_EST = 4'h4;
   localparam logic [3:0] ST_REL = 4'h8;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic        related;
      logic        direction;
      logic [15:0] length;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic        fwd_found;
      logic        rev_found;
      logic [3:0]  fwd_state;
      logic [63:0] fwd_packets;
      logic [63:0] fwd_bytes;
      logic [2:0]  inserts_done;
      logic        evicted;
   } rsp_type;

   typedef struct packed {
      logic [63:0] addr;
      logic [41:0] ppf;
   } key_type;

   typedef struct packed {
      key_type              key;
      logic [STAMP_W-1:0]   stamp;
   } kword_type;

   typedef struct packed {
      logic [3:0]  state;
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [31:0] since;
   } data_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] lru_idx;
   } srch_res_type;

   typedef enum logic [2:0] {
      OP_LOOK_REV,
      OP_LOOK_FWD,
      OP_INS_ICMPF,
      OP_INS_ICMPR,
      OP_INS_FWD,
      OP_INS_REV
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DREAD,
      S_DFWD,
      S_UPDATE,
      S_PLAN
   } fsm_type;

   function automatic logic [41:0] ports_key(input logic [15:0] sp, input logic [15:0] dp,
                                             input logic [7:0] pr, input logic rel,
                                             input logic dir);
      return {sp, dp, pr, rel, dir};
   endfunction

   // Forward state follows the reverse state one step at a time.
   function automatic logic [3:0] advance(input logic [3:0] rs, input logic [3:0] fs);
      logic [3:0] r;
      r = fs;
      if (rs == ST_NEW) begin
         if (fs == ST_NEW) r = fs | ST_RPL;
      end else if (rs == (ST_NEW | ST_RPL)) begin
         if (fs == ST_NEW) r = fs | ST_RPL;
         else if (fs == (ST_NEW | ST_RPL)) r = fs | ST_EST;
      end else if (rs == (ST_NEW | ST_RPL | ST_EST)) begin
         if (fs == (ST_NEW | ST_RPL)) r = fs | ST_EST;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/cntab_search.sv
// Key memory with a linear search engine: finds a key and the least recently used entry.
`default_nettype none
module cntab_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  cntab_pkg::key_type        key,
   input  logic [cntab_pkg::FILL_W-1:0] fill,
   input  logic                      wr_en,
   input  logic [cntab_pkg::IDX_W-1:0] wr_addr,
   input  cntab_pkg::kword_type      wr_data,
   output logic                      done,
   output cntab_pkg::srch_res_type   res
);

   cntab_pkg::kword_type mem [cntab_pkg::ENTRIES];
   cntab_pkg::kword_type rd_q_ff;

   logic active_ff, pend_ff, found_ff, first_ff;
   logic [cntab_pkg::FILL_W-1:0]  addr_ff;
   logic [cntab_pkg::IDX_W-1:0]   pend_idx_ff, idx_ff, lru_idx_ff;
   logic [cntab_pkg::STAMP_W-1:0] lru_stamp_ff;
   cntab_pkg::key_type            key_ff;

   logic issue, hit, older;

   assign issue = active_ff && !found_ff && (addr_ff < fill);
   assign hit   = pend_ff && !found_ff && (rd_q_ff.key == key_ff);
   assign older = pend_ff && (first_ff || (rd_q_ff.stamp < lru_stamp_ff));
   assign done  = active_ff && !pend_ff && (found_ff || (addr_ff >= fill));

   assign res = '{found: found_ff, idx: idx_ff, lru_idx: lru_idx_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[addr_ff[cntab_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         first_ff  <= 1'b1;
      end else if (start) begin
         active_ff <= 1'b1;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         first_ff  <= 1'b1;
      end else if (done) begin
         active_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (hit) found_ff <= 1'b1;
         if (older) first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff <= '0;
         key_ff  <= key;
      end else begin
         if (issue) begin
            addr_ff     <= addr_ff + cntab_pkg::FILL_W'(1);
            pend_idx_ff <= addr_ff[cntab_pkg::IDX_W-1:0];
         end
         if (hit) idx_ff <= pend_idx_ff;
         if (older) begin
            lru_idx_ff   <= pend_idx_ff;
            lru_stamp_ff <= rd_q_ff.stamp;
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/connection_tracking_table.sv
// Top level of the IPv4 five-tuple connection tracking table.
// One item is a parsed packet. It is taken when start is high and busy is low. Its one result
// appears for a single cycle with rsp_strobe high, in the first cycle that busy is low, and a
// new item may be taken at the edge that ends that cycle. The receiver cannot stall it. The
// block works on one item at a time. Each key search walks the filled part of the table one
// entry a cycle through the single read port of the key memory. A hit ends a search's walk early.
// An item makes two lookups and up to four inserts. It passes through the S_PLAN state after
// the lookups and after every insert, and through S_DREAD, S_DFWD and S_UPDATE to update a
// forward entry that was found. The most work falls on a UDP packet with both tuples missing
// from a full table, as each of its searches walks the whole table. No clearing pass follows
// reset: the table fills from entry 0 upwards and a fill count marks the valid part.
`default_nettype none
module connection_tracking_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cntab_pkg::req_type  req_item,
   output logic                rsp_strobe,
   output cntab_pkg::rsp_type  rsp_item
);

   // state and item registers
   cntab_pkg::fsm_type state_ff, state_in;
   cntab_pkg::op_type  op_ff, op_in;
   cntab_pkg::req_type req_ff, req_in;

   logic [cntab_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [cntab_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic rf_ff, rf_in, ff_ff, ff_in, ev_ff, ev_in;
   logic [cntab_pkg::IDX_W-1:0] ri_ff, ri_in, fi_ff, fi_in;
   logic [2:0]  ins_ff, ins_in;
   logic [3:0]  ost_ff, ost_in;
   logic [63:0] opk_ff, opk_in, oby_ff, oby_in;
   cntab_pkg::data_type fdat_ff, fdat_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   cntab_pkg::rsp_type rsp_item_ff, rsp_item_in;

   // data memory: state, counters and time stamp of every flow
   cntab_pkg::data_type dmem [cntab_pkg::ENTRIES];
   cntab_pkg::data_type drd_q_ff;
   logic dwr_en;
   logic [cntab_pkg::IDX_W-1:0] dwr_addr, drd_addr;
   cntab_pkg::data_type dwr_data;

   // key memory port and search engine hookup
   logic kwr_en, srch_start, srch_done;
   logic [cntab_pkg::IDX_W-1:0] kwr_addr;
   cntab_pkg::kword_type kwr_data;
   cntab_pkg::key_type srch_key, cur_key;
   cntab_pkg::srch_res_type srch_res;
   cntab_pkg::data_type ins_data, upd_data;

   // keys of the four tuples an item can touch
   cntab_pkg::key_type key_fwd, key_rev, key_icf, key_icr;
   logic need_icf, need_icr, need_fwd, need_rev;
   logic have_next;
   cntab_pkg::op_type nxt_op;
   logic [cntab_pkg::IDX_W-1:0] ins_idx;

   assign busy       = (state_ff != cntab_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // latch the item on acceptance; keys follow the latched (or arriving) item
   assign req_in = (state_ff == cntab_pkg::S_IDLE && start) ? req_item : req_ff;

   assign key_fwd = '{addr: {req_in.src_addr, req_in.dst_addr},
                      ppf:  cntab_pkg::ports_key(req_in.src_port, req_in.dst_port,
                               req_in.protocol, req_in.related, req_in.direction)};
   assign key_rev = '{addr: {req_in.dst_addr, req_in.src_addr},
                      ppf:  cntab_pkg::ports_key(req_in.dst_port, req_in.src_port,
                               req_in.protocol, req_in.related, ~req_in.direction)};
   assign key_icf = '{addr: {req_in.src_addr, req_in.dst_addr},
                      ppf:  cntab_pkg::ports_key(16'd0, 16'd0, cntab_pkg::PROTO_ICMP,
                               1'b1, req_in.direction)};
   assign key_icr = '{addr: {req_in.dst_addr, req_in.src_addr},
                      ppf:  cntab_pkg::ports_key(16'd0, 16'd0, cntab_pkg::PROTO_ICMP,
                               1'b1, ~req_in.direction)};

   // inserts still owed by this item, in table order
   assign need_icf = !ff_ff && (req_ff.protocol == cntab_pkg::PROTO_UDP);
   assign need_icr = !rf_ff && (req_ff.protocol == cntab_pkg::PROTO_UDP);
   assign need_fwd = !ff_ff;
   assign need_rev = !rf_ff;

   always_comb begin
      have_next = 1'b1;
      nxt_op    = cntab_pkg::OP_INS_REV;
      priority if (need_icf && op_ff < cntab_pkg::OP_INS_ICMPF) begin
         nxt_op = cntab_pkg::OP_INS_ICMPF;
      end else if (need_icr && op_ff < cntab_pkg::OP_INS_ICMPR) begin
         nxt_op = cntab_pkg::OP_INS_ICMPR;
      end else if (need_fwd && op_ff < cntab_pkg::OP_INS_FWD) begin
         nxt_op = cntab_pkg::OP_INS_FWD;
      end else if (need_rev && op_ff < cntab_pkg::OP_INS_REV) begin
         nxt_op = cntab_pkg::OP_INS_REV;
      end else begin
         have_next = 1'b0;
      end
   end

   // key and fresh entry contents of the operation in hand
   always_comb begin
      unique case (op_ff)
         cntab_pkg::OP_LOOK_REV:  cur_key = key_rev;
         cntab_pkg::OP_LOOK_FWD:  cur_key = key_fwd;
         cntab_pkg::OP_INS_ICMPF: cur_key = key_icf;
         cntab_pkg::OP_INS_ICMPR: cur_key = key_icr;
         cntab_pkg::OP_INS_FWD:   cur_key = key_fwd;
         default:                 cur_key = key_rev;
      endcase
      unique case (op_ff)
         cntab_pkg::OP_INS_FWD:
            ins_data = '{state: cntab_pkg::ST_NEW, packets: 64'd1,
                         bytes: {48'd0, req_ff.length}, since: req_ff.now_seconds};
         cntab_pkg::OP_INS_REV:
            ins_data = '{state: cntab_pkg::ST_NEW, packets: 64'd0,
                         bytes: 64'd0, since: req_ff.now_seconds};
         default:
            ins_data = '{state: cntab_pkg::ST_REL, packets: 64'd0,
                         bytes: 64'd0, since: req_ff.now_seconds};
      endcase
      unique case (op_in)
         cntab_pkg::OP_LOOK_REV:  srch_key = key_rev;
         cntab_pkg::OP_LOOK_FWD:  srch_key = key_fwd;
         cntab_pkg::OP_INS_ICMPF: srch_key = key_icf;
         cntab_pkg::OP_INS_ICMPR: srch_key = key_icr;
         cntab_pkg::OP_INS_FWD:   srch_key = key_fwd;
         default:                 srch_key = key_rev;
      endcase
   end

   // counted and advanced forward entry; drd_q_ff holds the reverse entry here
   assign upd_data = '{state:   cntab_pkg::advance(drd_q_ff.state, fdat_ff.state),
                       packets: fdat_ff.packets + 64'd1,
                       bytes:   fdat_ff.bytes + {48'd0, req_ff.length},
                       since:   req_ff.now_seconds};

   // slot for an insert: the key's own entry, else the next free one, else the oldest
   always_comb begin
      if (srch_res.found) ins_idx = srch_res.idx;
      else if (fill_ff < cntab_pkg::FILL_W'(cntab_pkg::ENTRIES))
         ins_idx = fill_ff[cntab_pkg::IDX_W-1:0];
      else ins_idx = srch_res.lru_idx;
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      fill_in       = fill_ff;
      stamp_in      = stamp_ff;
      rf_in         = rf_ff;
      ff_in         = ff_ff;
      ri_in         = ri_ff;
      fi_in         = fi_ff;
      ins_in        = ins_ff;
      ev_in         = ev_ff;
      ost_in        = ost_ff;
      opk_in        = opk_ff;
      oby_in        = oby_ff;
      fdat_in       = fdat_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      srch_start    = 1'b0;
      kwr_en        = 1'b0;
      kwr_addr      = srch_res.idx;
      kwr_data      = '{key: cur_key, stamp: stamp_ff};
      dwr_en        = 1'b0;
      dwr_addr      = ins_idx;
      dwr_data      = ins_data;
      drd_addr      = fi_ff;

      unique case (state_ff)
         cntab_pkg::S_IDLE: begin
            if (start) begin
               op_in      = cntab_pkg::OP_LOOK_REV;
               ins_in     = 3'd0;
               ev_in      = 1'b0;
               srch_start = 1'b1;
               state_in   = cntab_pkg::S_SEARCH;
            end
         end
         cntab_pkg::S_SEARCH: begin
            if (srch_done) begin
               unique case (op_ff)
                  cntab_pkg::OP_LOOK_REV: begin
                     rf_in = srch_res.found;
                     ri_in = srch_res.idx;
                     if (srch_res.found) begin
                        // touch: make the entry the most recent
                        kwr_en   = 1'b1;
                        stamp_in = stamp_ff + cntab_pkg::STAMP_W'(1);
                     end
                     op_in      = cntab_pkg::OP_LOOK_FWD;
                     srch_start = 1'b1;
                  end
                  cntab_pkg::OP_LOOK_FWD: begin
                     ff_in = srch_res.found;
                     fi_in = srch_res.idx;
                     if (srch_res.found) begin
                        kwr_en   = 1'b1;
                        stamp_in = stamp_ff + cntab_pkg::STAMP_W'(1);
                        state_in = cntab_pkg::S_DREAD;
                     end else begin
                        state_in = cntab_pkg::S_PLAN;
                     end
                  end
                  default: begin
                     kwr_en   = 1'b1;
                     kwr_addr = ins_idx;
                     stamp_in = stamp_ff + cntab_pkg::STAMP_W'(1);
                     dwr_en   = 1'b1;
                     ins_in   = ins_ff + 3'd1;
                     if (!srch_res.found) begin
                        if (fill_ff < cntab_pkg::FILL_W'(cntab_pkg::ENTRIES))
                           fill_in = fill_ff + cntab_pkg::FILL_W'(1);
                        else
                           ev_in = 1'b1;
                     end
                     if (op_ff == cntab_pkg::OP_INS_FWD) begin
                        ost_in = ins_data.state;
                        opk_in = ins_data.packets;
                        oby_in = ins_data.bytes;
                     end
                     state_in = cntab_pkg::S_PLAN;
                  end
               endcase
            end
         end
         cntab_pkg::S_DREAD: begin
            drd_addr = fi_ff;
            state_in = cntab_pkg::S_DFWD;
         end
         cntab_pkg::S_DFWD: begin
            fdat_in  = drd_q_ff;
            drd_addr = ri_ff;
            state_in = cntab_pkg::S_UPDATE;
         end
         cntab_pkg::S_UPDATE: begin
            if (rf_ff) begin
               dwr_en   = 1'b1;
               dwr_addr = fi_ff;
               dwr_data = upd_data;
               kwr_en   = 1'b1;
               kwr_addr = fi_ff;
               kwr_data = '{key: key_fwd, stamp: stamp_ff};
               stamp_in = stamp_ff + cntab_pkg::STAMP_W'(1);
               ost_in   = upd_data.state;
               opk_in   = upd_data.packets;
               oby_in   = upd_data.bytes;
            end else begin
               // forward found, reverse missing: report the entry as it stands
               ost_in = fdat_ff.state;
               opk_in = fdat_ff.packets;
               oby_in = fdat_ff.bytes;
            end
            state_in = cntab_pkg::S_PLAN;
         end
         cntab_pkg::S_PLAN: begin
            if (have_next) begin
               op_in      = nxt_op;
               srch_start = 1'b1;
               state_in   = cntab_pkg::S_SEARCH;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{fwd_found: ff_ff, rev_found: rf_ff, fwd_state: ost_ff,
                                 fwd_packets: opk_ff, fwd_bytes: oby_ff,
                                 inserts_done: ins_ff, evicted: ev_ff};
               state_in      = cntab_pkg::S_IDLE;
            end
         end
         default: state_in = cntab_pkg::S_IDLE;
      endcase
   end

   cntab_search u_search (
      .clock   (clock),
      .reset   (reset),
      .start   (srch_start),
      .key     (srch_key),
      .fill    (fill_ff),
      .wr_en   (kwr_en),
      .wr_addr (kwr_addr),
      .wr_data (kwr_data),
      .done    (srch_done),
      .res     (srch_res)
   );

   always_ff @(posedge clock) begin
      if (dwr_en) begin
         dmem[dwr_addr] <= dwr_data;
      end
      drd_q_ff <= dmem[drd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cntab_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state cleared on reset; the table empties by dropping the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         stamp_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         op_ff         <= cntab_pkg::OP_LOOK_REV;
      end else begin
         fill_ff       <= fill_in;
         stamp_ff      <= stamp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         op_ff         <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rf_ff       <= rf_in;
      ff_ff       <= ff_in;
      ri_ff       <= ri_in;
      fi_ff       <= fi_in;
      ins_ff      <= ins_in;
      ev_ff       <= ev_in;
      ost_ff      <= ost_in;
      opk_ff      <= opk_in;
      oby_ff      <= oby_in;
      fdat_ff     <= fdat_in;
      rsp_item_ff <= rsp_item_in;
   end

   // a result is a single-cycle pulse and the block is free when it shows
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");

   a_inserts_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.inserts_done <= 3'd4) else $error("too many inserts");

   a_new_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.fwd_found |->
         rsp_item.fwd_state == cntab_pkg::ST_NEW && rsp_item.fwd_packets == 64'd1)
      else $error("fresh forward entry wrong");

   a_evict_needs_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.evicted |-> rsp_item.inserts_done != 3'd0)
      else $error("eviction without insert");

endmodule
`default_nettype wire
